/* hdl/smrc_pkg.sv */
// ----------------------------------------------------------------------------
// smrc_pkg
// Shared types, codes and constants of the sumo robot match controller.
// ----------------------------------------------------------------------------
package smrc_pkg;

  // widths
  localparam int AdcBits     = 10;
  localparam int TimeBits    = 32;
  localparam int EchoBits    = 13;
  localparam int MsBits      = 16;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 16;

  // referee codes
  localparam logic [31:0] CodeReady = 32'd3994155780;
  localparam logic [31:0] CodeStart = 32'd3977444100;
  localparam logic [31:0] CodeStop  = 32'd3960732420;

  // timing and speeds
  localparam int unsigned PingGapMs = 30;
  localparam logic [7:0] SpdAttack = 8'd255;
  localparam logic [7:0] SpdCurve  = 8'd190;
  localparam logic [7:0] SpdSearch = 8'd110;
  localparam logic [7:0] SpdBack   = 8'd200;
  localparam logic [7:0] SpdTurn   = 8'd180;

  // motor direction codes
  localparam logic [1:0] DirOff = 2'd0;
  localparam logic [1:0] DirFwd = 2'd1;
  localparam logic [1:0] DirRev = 2'd2;

  // match phase codes as reported
  localparam logic [1:0] PhaseWait  = 2'd0;
  localparam logic [1:0] PhaseReady = 2'd1;
  localparam logic [1:0] PhaseFight = 2'd2;
  localparam logic [1:0] PhaseStop  = 2'd3;

  // target direction codes
  localparam logic [1:0] TgtNone   = 2'd0;
  localparam logic [1:0] TgtLeft   = 2'd1;
  localparam logic [1:0] TgtRight  = 2'd2;
  localparam logic [1:0] TgtCentre = 2'd3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_EDGE_THRESHOLD   = 3'd0,
    CFG_EDGE_ABOVE       = 3'd1,
    CFG_ECHO_MIN_US      = 3'd2,
    CFG_ECHO_MAX_US      = 3'd3,
    CFG_REVERSE_MS       = 3'd4,
    CFG_TURN_MS          = 3'd5,
    CFG_TARGET_MEMORY_MS = 3'd6,
    CFG_READING_VALID_MS = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [AdcBits-1:0]  edge_threshold;
    logic                edge_above_polarity;
    logic [EchoBits-1:0] echo_min_us;
    logic [EchoBits-1:0] echo_max_us;
    logic [MsBits-1:0]   reverse_ms;
    logic [MsBits-1:0]   turn_ms;
    logic [MsBits-1:0]   target_memory_ms;
    logic [MsBits-1:0]   reading_valid_ms;
  } smrc_cfg_t;

  localparam smrc_cfg_t CfgReset = '{
    edge_threshold:      AdcBits'(450),
    edge_above_polarity: 1'b1,
    echo_min_us:         EchoBits'(234),
    echo_max_us:         EchoBits'(4664),
    reverse_ms:          MsBits'(250),
    turn_ms:             MsBits'(300),
    target_memory_ms:    MsBits'(120),
    reading_valid_ms:    MsBits'(150)
  };

  typedef struct packed {
    logic [1:0] ldir;
    logic [1:0] rdir;
    logic [7:0] lpwm;
    logic [7:0] rpwm;
  } motor_t;

  typedef struct packed {
    logic [31:0]         now_ms;
    logic                ir_valid;
    logic [31:0]         ir_code;
    logic [AdcBits-1:0]  edge_left_first;
    logic [AdcBits-1:0]  edge_left_second;
    logic [AdcBits-1:0]  edge_right_first;
    logic [AdcBits-1:0]  edge_right_second;
    logic                echo_valid;
    logic                echo_side;
    logic [EchoBits-1:0] echo_time_us;
  } smrc_in_t;

  typedef struct packed {
    logic [1:0] left_motor_dir;
    logic [1:0] right_motor_dir;
    logic [7:0] left_motor_pwm;
    logic [7:0] right_motor_pwm;
    logic [1:0] match_phase;
    logic       ping_request;
    logic       ping_target_side;
  } smrc_out_t;

endpackage

/* hdl/smrc_if.sv */
// ----------------------------------------------------------------------------
// smrc_if
// Valid/ready channels of the match controller: control passes in,
// motor and ping results out.
// ----------------------------------------------------------------------------
interface smrc_in_if;
  import smrc_pkg::*;

  logic     valid;
  logic     ready;
  smrc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smrc_out_if;
  import smrc_pkg::*;

  logic      valid;
  logic      ready;
  smrc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/sumo_robot_match_controller_core.sv */
// ----------------------------------------------------------------------------
// sumo_robot_match_controller_core
// Match controller of a sumo robot: referee codes, edge escape, ultrasonic
// ping scheduling and target chase, one result beat per control pass.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one control pass per beat (timestamp, referee code, edge
//   samples, optional echo). rsp_o returns exactly one result beat for it:
//   motor directions and duties, match phase and a ping request.
//   The whole pass is evaluated combinationally from the accepted beat and the
//   controller state; the result sits in an output register in the cycle after
//   acceptance. Throughput is one pass per cycle: req_i.ready stays high while
//   the output register is empty or being taken in the same cycle.
//   When the receiver stalls, the result holds and req_i.ready drops until it
//   is taken; no pass is lost or repeated. Reset loads the register defaults,
//   puts the match in waiting with motors off and arms an immediate first ping.
//   Registers must be written through the cfg_* port only while no pass is in
//   flight; the block does not enforce this. Every index 0..7 is a register.
// ----------------------------------------------------------------------------
module sumo_robot_match_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [smrc_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [smrc_pkg::CfgDataBits-1:0] cfg_wdata_i,
  smrc_in_if.sink                          req_i,
  smrc_out_if.source                       rsp_o
);
  import smrc_pkg::*;

  typedef enum logic [3:0] {
    MODE_WAIT  = 4'b0001,
    MODE_READY = 4'b0010,
    MODE_FIGHT = 4'b0100,
    MODE_STOP  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_REV  = 3'b010,
    ESC_TURN = 3'b100
  } esc_e;

  // configuration registers
  smrc_cfg_t cfg_q;

  // controller state
  mode_e                mode_q, mode_d;
  esc_e                 esc_q, esc_d;
  logic                 esc_left_q, esc_left_d;
  logic [TimeBits-1:0]  esc_start_q, esc_start_d;
  logic [EchoBits-1:0]  echo_store_q [2];
  logic [EchoBits-1:0]  echo_store_d [2];
  logic [1:0]           echo_present_q, echo_present_d;
  logic [TimeBits-1:0]  echo_stamp_q [2];
  logic [TimeBits-1:0]  echo_stamp_d [2];
  logic                 ping_next_left_q, ping_next_left_d;
  logic [TimeBits-1:0]  ping_last_q, ping_last_d;
  logic                 ping_imm_q, ping_imm_d;
  logic [1:0]           tgt_dir_q, tgt_dir_d;
  logic [TimeBits-1:0]  tgt_seen_q, tgt_seen_d;
  motor_t               motor_q, motor_d;

  // output register
  logic      out_valid_q;
  smrc_out_t out_q;
  smrc_out_t out_d;

  // pass-local values
  logic                acc;
  logic [TimeBits-1:0] now;
  logic [TimeBits-1:0] esc_age;
  logic [TimeBits-1:0] ping_age;
  logic [TimeBits-1:0] tgt_age;
  logic                edge_l, edge_r;
  logic                hit_l, hit_r;
  logic                ping, ping_side;
  logic                clr;

  // edge test on one sample
  function automatic logic is_edge(logic [AdcBits-1:0] v, smrc_cfg_t c);
    if (c.edge_above_polarity) begin
      return v > c.edge_threshold;
    end
    return v < c.edge_threshold;
  endfunction

  // fresh in-range echo on one side
  function automatic logic echo_hit(logic present, logic [EchoBits-1:0] store,
                                    logic [TimeBits-1:0] stamp,
                                    logic [TimeBits-1:0] t, smrc_cfg_t c);
    logic [TimeBits-1:0] age;
    age = t - stamp;
    if (!present) return 1'b0;
    if (age > TimeBits'(c.reading_valid_ms)) return 1'b0;
    if (store == '0) return 1'b0;
    return (store >= c.echo_min_us) && (store <= c.echo_max_us);
  endfunction

  // attack command for a target direction
  function automatic motor_t attack(logic [1:0] d);
    motor_t m;
    m.ldir = DirFwd;
    m.rdir = DirFwd;
    case (d)
      TgtCentre: begin m.lpwm = SpdAttack; m.rpwm = SpdAttack; end
      TgtLeft:   begin m.lpwm = SpdCurve;  m.rpwm = SpdAttack; end
      default:   begin m.lpwm = SpdAttack; m.rpwm = SpdCurve;  end
    endcase
    return m;
  endfunction

  function automatic motor_t drive(logic [1:0] ld, logic [1:0] rd,
                                   logic [7:0] lp, logic [7:0] rp);
    motor_t m;
    m.ldir = ld;
    m.rdir = rd;
    m.lpwm = lp;
    m.rpwm = rp;
    return m;
  endfunction

  // handshake
  assign acc         = req_i.valid && req_i.ready;
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;
  assign now         = req_i.data.now_ms[TimeBits-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EDGE_THRESHOLD:   cfg_q.edge_threshold      <= cfg_wdata_i[AdcBits-1:0];
        CFG_EDGE_ABOVE:       cfg_q.edge_above_polarity <= cfg_wdata_i[0];
        CFG_ECHO_MIN_US:      cfg_q.echo_min_us         <= cfg_wdata_i[EchoBits-1:0];
        CFG_ECHO_MAX_US:      cfg_q.echo_max_us         <= cfg_wdata_i[EchoBits-1:0];
        CFG_REVERSE_MS:       cfg_q.reverse_ms          <= cfg_wdata_i[MsBits-1:0];
        CFG_TURN_MS:          cfg_q.turn_ms             <= cfg_wdata_i[MsBits-1:0];
        CFG_TARGET_MEMORY_MS: cfg_q.target_memory_ms    <= cfg_wdata_i[MsBits-1:0];
        CFG_READING_VALID_MS: cfg_q.reading_valid_ms    <= cfg_wdata_i[MsBits-1:0];
        default: ;
      endcase
    end
  end

  // one control pass
  always_comb begin
    mode_d           = mode_q;
    esc_d            = esc_q;
    esc_left_d       = esc_left_q;
    esc_start_d      = esc_start_q;
    echo_store_d     = echo_store_q;
    echo_present_d   = echo_present_q;
    echo_stamp_d     = echo_stamp_q;
    ping_next_left_d = ping_next_left_q;
    ping_last_d      = ping_last_q;
    ping_imm_d       = ping_imm_q;
    tgt_dir_d        = tgt_dir_q;
    tgt_seen_d       = tgt_seen_q;
    motor_d          = motor_q;
    ping             = 1'b0;
    ping_side        = 1'b0;
    clr              = 1'b0;
    hit_l            = 1'b0;
    hit_r            = 1'b0;

    // referee
    if (req_i.data.ir_valid) begin
      if (req_i.data.ir_code == CodeStop) begin
        mode_d = MODE_STOP;
        clr    = 1'b1;
      end else if (mode_q == MODE_STOP) begin
        // stopped for good
      end else if (req_i.data.ir_code == CodeReady) begin
        mode_d = MODE_READY;
        clr    = 1'b1;
      end else if (req_i.data.ir_code == CodeStart && mode_q == MODE_READY) begin
        mode_d           = MODE_FIGHT;
        clr              = 1'b1;
        ping_imm_d       = 1'b1;
        ping_next_left_d = 1'b1;
      end
    end
    if (clr) begin
      esc_d      = ESC_IDLE;
      esc_left_d = 1'b0;
    end

    esc_age = now - esc_start_d;
    edge_l  = is_edge(req_i.data.edge_left_first, cfg_q) &&
              is_edge(req_i.data.edge_left_second, cfg_q);
    edge_r  = is_edge(req_i.data.edge_right_first, cfg_q) &&
              is_edge(req_i.data.edge_right_second, cfg_q);

    if (mode_d != MODE_FIGHT) begin
      // halted: motors off
      motor_d    = drive(DirOff, DirOff, 8'd0, 8'd0);
      esc_d      = ESC_IDLE;
      esc_left_d = 1'b0;
    end else begin
      unique case (esc_d)
        ESC_REV: begin
          if (esc_age >= TimeBits'(cfg_q.reverse_ms)) begin
            esc_d       = ESC_TURN;
            esc_start_d = now;
            motor_d     = esc_left_d ? drive(DirFwd, DirRev, SpdTurn, SpdTurn)
                                     : drive(DirRev, DirFwd, SpdTurn, SpdTurn);
          end
        end
        ESC_TURN: begin
          // turn end keeps the turn command for this pass
          if (esc_age >= TimeBits'(cfg_q.turn_ms)) begin
            esc_d      = ESC_IDLE;
            esc_left_d = 1'b0;
            clr        = 1'b1;
          end
        end
        default: begin
          if (edge_l || edge_r) begin
            // border seen: back away, then turn away from it
            clr         = 1'b1;
            esc_left_d  = edge_r && !edge_l;
            esc_d       = ESC_REV;
            esc_start_d = now;
            motor_d     = drive(DirRev, DirRev, SpdBack, SpdBack);
          end
        end
      endcase
    end

    // drop stored echoes and target memory
    if (clr) begin
      for (int i = 0; i < 2; i++) begin
        echo_store_d[i] = '0;
        echo_stamp_d[i] = '0;
      end
      echo_present_d = '0;
      tgt_dir_d      = TgtNone;
      tgt_seen_d     = '0;
    end

    ping_age = now - ping_last_d;

    // ultrasonic stage and chase decision
    if (mode_d == MODE_FIGHT && esc_q != ESC_REV && esc_q != ESC_TURN &&
        esc_d == ESC_IDLE && !(edge_l || edge_r)) begin
      if (req_i.data.echo_valid) begin
        echo_store_d[req_i.data.echo_side]   = req_i.data.echo_time_us;
        echo_present_d[req_i.data.echo_side] = 1'b1;
        echo_stamp_d[req_i.data.echo_side]   = now;
      end
      if (ping_imm_d || ping_age >= TimeBits'(PingGapMs)) begin
        ping_imm_d       = 1'b0;
        ping_last_d      = now;
        ping             = 1'b1;
        ping_side        = !ping_next_left_d;
        ping_next_left_d = !ping_next_left_d;
      end

      hit_l   = echo_hit(echo_present_d[0], echo_store_d[0], echo_stamp_d[0],
                         now, cfg_q);
      hit_r   = echo_hit(echo_present_d[1], echo_store_d[1], echo_stamp_d[1],
                         now, cfg_q);
      tgt_age = now - tgt_seen_d;
      if (hit_l || hit_r) begin
        tgt_dir_d  = (hit_l && hit_r) ? TgtCentre : (hit_l ? TgtLeft : TgtRight);
        tgt_seen_d = now;
        motor_d    = attack(tgt_dir_d);
      end else if (tgt_dir_d != TgtNone &&
                   tgt_age <= TimeBits'(cfg_q.target_memory_ms)) begin
        motor_d = attack(tgt_dir_d);
      end else begin
        // search by spinning in place
        tgt_dir_d = TgtNone;
        motor_d   = drive(DirRev, DirFwd, SpdSearch, SpdSearch);
      end
    end else begin
      tgt_age = now - tgt_seen_d;
    end

    // result beat
    out_d.left_motor_dir   = motor_d.ldir;
    out_d.right_motor_dir  = motor_d.rdir;
    out_d.left_motor_pwm   = motor_d.lpwm;
    out_d.right_motor_pwm  = motor_d.rpwm;
    out_d.ping_request     = ping;
    out_d.ping_target_side = ping && ping_side;
    unique case (mode_d)
      MODE_READY: out_d.match_phase = PhaseReady;
      MODE_FIGHT: out_d.match_phase = PhaseFight;
      MODE_STOP:  out_d.match_phase = PhaseStop;
      default:    out_d.match_phase = PhaseWait;
    endcase
  end

  // state update on an accepted pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_WAIT;
      esc_q            <= ESC_IDLE;
      esc_left_q       <= 1'b0;
      esc_start_q      <= '0;
      echo_store_q[0]  <= '0;
      echo_store_q[1]  <= '0;
      echo_present_q   <= '0;
      echo_stamp_q[0]  <= '0;
      echo_stamp_q[1]  <= '0;
      ping_next_left_q <= 1'b1;
      ping_last_q      <= '0;
      ping_imm_q       <= 1'b1;
      tgt_dir_q        <= TgtNone;
      tgt_seen_q       <= '0;
      motor_q          <= '0;
    end else if (acc) begin
      mode_q           <= mode_d;
      esc_q            <= esc_d;
      esc_left_q       <= esc_left_d;
      esc_start_q      <= esc_start_d;
      echo_store_q     <= echo_store_d;
      echo_present_q   <= echo_present_d;
      echo_stamp_q     <= echo_stamp_d;
      ping_next_left_q <= ping_next_left_d;
      ping_last_q      <= ping_last_d;
      ping_imm_q       <= ping_imm_d;
      tgt_dir_q        <= tgt_dir_d;
      tgt_seen_q       <= tgt_seen_d;
      motor_q          <= motor_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= out_d;
    end
  end

  // stop is permanent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_STOP |=> mode_q == MODE_STOP)
    else $error("match left stopped mode");

  // escape only runs while fighting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q != ESC_IDLE |-> mode_q == MODE_FIGHT)
    else $error("escape active outside fight");

  // every accepted pass leaves a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted pass without result beat");

  // motors are off in any result outside a fight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.match_phase != PhaseFight |->
      out_q.left_motor_dir == DirOff && out_q.right_motor_dir == DirOff &&
      out_q.left_motor_pwm == 8'd0 && out_q.right_motor_pwm == 8'd0)
    else $error("motors driven outside fight");

endmodule

/* verif/tb_sumo_robot_match_controller_core.sv */
// ----------------------------------------------------------------------------
// tb_sumo_robot_match_controller_core
// Self-checking bench for the match controller. Control passes are driven on
// the request channel under random source gaps and sink stalls. Every
// accepted pass is run through a behavioral copy of the controller, which
// tracks the referee state, edge escape, ping schedule and target memory.
// The result beats are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_sumo_robot_match_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import smrc_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int HoldCycles = 300;

  typedef enum logic [1:0] {ESC_OFF, ESC_BACK, ESC_TURN} escape_e;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SNK_STALLS, FLOW_BOTH} flow_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;

  smrc_in_if  req_if ();
  smrc_out_if rsp_if ();

  sumo_robot_match_controller_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // controller copy: settings and state
  smrc_cfg_t   cfg_m = CfgReset;
  logic [1:0]  mode_q = PhaseWait;
  escape_e     esc_q = ESC_OFF;
  logic        esc_turn_left = 1'b0;
  logic [31:0] esc_start = '0;
  logic [EchoBits-1:0] echo_us [2] = '{default: '0};
  logic        echo_seen [2] = '{default: 1'b0};
  logic [31:0] echo_at [2] = '{default: '0};
  logic        ping_left_next = 1'b1;
  logic [31:0] ping_at = '0;
  logic        ping_first = 1'b1;
  logic [1:0]  tgt_dir = TgtNone;
  logic [31:0] tgt_at = '0;
  motor_t      motor = '0;

  // bench bookkeeping
  smrc_in_t    pass_q [$];
  smrc_out_t   predicted_cmd_q [$];
  logic [31:0] gen_ms = '0;
  logic        rsp_hold = 1'b0;
  flow_e       flow = FLOW_FREE;
  int unsigned flow_left = 200;
  int          err_cnt = 0;
  int          beat_cnt = 0;

  function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] then);
    return now - then;
  endfunction

  function automatic logic on_line(logic [AdcBits-1:0] v);
    if (cfg_m.edge_above_polarity) return v > cfg_m.edge_threshold;
    return v < cfg_m.edge_threshold;
  endfunction

  function automatic void drop_target();
    for (int s = 0; s < 2; s++) begin
      echo_us[s] = '0;
      echo_seen[s] = 1'b0;
      echo_at[s] = '0;
    end
    tgt_dir = TgtNone;
    tgt_at = '0;
  endfunction

  function automatic logic echo_in_range(int s, logic [31:0] now);
    return echo_seen[s] && ms_since(now, echo_at[s]) <= cfg_m.reading_valid_ms &&
           echo_us[s] != 0 && echo_us[s] >= cfg_m.echo_min_us &&
           echo_us[s] <= cfg_m.echo_max_us;
  endfunction

  // straight attack on a centred target, curve toward a side target
  function automatic motor_t chase(logic [1:0] d);
    motor_t m;
    if (d == TgtCentre) m = '{DirFwd, DirFwd, SpdAttack, SpdAttack};
    else if (d == TgtLeft) m = '{DirFwd, DirFwd, SpdCurve, SpdAttack};
    else m = '{DirFwd, DirFwd, SpdAttack, SpdCurve};
    return m;
  endfunction

  // one control pass: referee, edge escape, ping schedule, target decision
  task automatic run_control_pass(input smrc_in_t p, output smrc_out_t r);
    logic line_l, line_r, hit_l, hit_r, ping, side;
    ping = 1'b0;
    side = 1'b0;
    if (p.ir_valid) begin
      if (p.ir_code == CodeStop) begin
        mode_q = PhaseStop;
        esc_q = ESC_OFF;
        esc_turn_left = 1'b0;
        drop_target();
      end else if (mode_q != PhaseStop) begin
        if (p.ir_code == CodeReady) begin
          mode_q = PhaseReady;
          esc_q = ESC_OFF;
          esc_turn_left = 1'b0;
          drop_target();
        end else if (p.ir_code == CodeStart && mode_q == PhaseReady) begin
          mode_q = PhaseFight;
          esc_q = ESC_OFF;
          esc_turn_left = 1'b0;
          drop_target();
          ping_first = 1'b1;
          ping_left_next = 1'b1;
        end
      end
    end

    if (mode_q != PhaseFight) begin
      motor = '{DirOff, DirOff, 8'd0, 8'd0};
      if (mode_q != PhaseStop) begin
        esc_q = ESC_OFF;
        esc_turn_left = 1'b0;
      end
    end else if (esc_q == ESC_BACK) begin
      // backing off, then turn away from the line
      if (ms_since(p.now_ms, esc_start) >= cfg_m.reverse_ms) begin
        esc_q = ESC_TURN;
        esc_start = p.now_ms;
        if (esc_turn_left) motor = '{DirFwd, DirRev, SpdTurn, SpdTurn};
        else motor = '{DirRev, DirFwd, SpdTurn, SpdTurn};
      end
    end else if (esc_q == ESC_TURN) begin
      // turn end keeps the turn command for this pass
      if (ms_since(p.now_ms, esc_start) >= cfg_m.turn_ms) begin
        esc_q = ESC_OFF;
        esc_turn_left = 1'b0;
        drop_target();
      end
    end else begin
      line_l = on_line(p.edge_left_first) && on_line(p.edge_left_second);
      line_r = on_line(p.edge_right_first) && on_line(p.edge_right_second);
      if (line_l || line_r) begin
        drop_target();
        esc_turn_left = line_r && !line_l;
        esc_q = ESC_BACK;
        esc_start = p.now_ms;
        motor = '{DirRev, DirRev, SpdBack, SpdBack};
      end else begin
        // store the echo, then alternate pings
        if (p.echo_valid) begin
          echo_us[p.echo_side] = p.echo_time_us;
          echo_seen[p.echo_side] = 1'b1;
          echo_at[p.echo_side] = p.now_ms;
        end
        if (ping_first || ms_since(p.now_ms, ping_at) >= PingGapMs) begin
          ping_first = 1'b0;
          ping_at = p.now_ms;
          ping = 1'b1;
          side = !ping_left_next;
          ping_left_next = !ping_left_next;
        end
        hit_l = echo_in_range(0, p.now_ms);
        hit_r = echo_in_range(1, p.now_ms);
        if (hit_l || hit_r) begin
          tgt_dir = (hit_l && hit_r) ? TgtCentre : (hit_l ? TgtLeft : TgtRight);
          tgt_at = p.now_ms;
          motor = chase(tgt_dir);
        end else if (tgt_dir != TgtNone &&
                     ms_since(p.now_ms, tgt_at) <= cfg_m.target_memory_ms) begin
          motor = chase(tgt_dir);
        end else begin
          tgt_dir = TgtNone;
          motor = '{DirRev, DirFwd, SpdSearch, SpdSearch};
        end
      end
    end

    r.left_motor_dir = motor.ldir;
    r.right_motor_dir = motor.rdir;
    r.left_motor_pwm = motor.lpwm;
    r.right_motor_pwm = motor.rpwm;
    r.match_phase = mode_q;
    r.ping_request = ping;
    r.ping_target_side = ping & side;
  endtask

  // stimulus helpers
  function automatic smrc_in_t mk_pass(logic [31:0] now, logic iv, logic [31:0] code,
                                       logic [AdcBits-1:0] lf, logic [AdcBits-1:0] ls,
                                       logic [AdcBits-1:0] rf, logic [AdcBits-1:0] rs,
                                       logic ev, logic es, logic [EchoBits-1:0] et);
    smrc_in_t p;
    p = '{now, iv, code, lf, ls, rf, rs, ev, es, et};
    return p;
  endfunction

  function automatic logic [AdcBits-1:0] line_sample();
    if (cfg_m.edge_above_polarity) begin
      if (cfg_m.edge_threshold == '1) return AdcBits'($urandom);
      return AdcBits'($urandom_range(1023, cfg_m.edge_threshold + 1));
    end
    if (cfg_m.edge_threshold == '0) return AdcBits'($urandom);
    return AdcBits'($urandom_range(cfg_m.edge_threshold - 1, 0));
  endfunction

  function automatic logic [AdcBits-1:0] surface_sample();
    if (cfg_m.edge_above_polarity) return AdcBits'($urandom_range(cfg_m.edge_threshold, 0));
    return AdcBits'($urandom_range(1023, cfg_m.edge_threshold));
  endfunction

  // confirmed line, half-seen line, noise or plain surface
  function automatic logic [2*AdcBits-1:0] sensor_pair();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return {line_sample(), line_sample()};
    if (r < 6) return {line_sample(), surface_sample()};
    if (r < 10) return {surface_sample(), line_sample()};
    if (r < 14) return {AdcBits'($urandom), AdcBits'($urandom)};
    return {surface_sample(), surface_sample()};
  endfunction

  function automatic logic [EchoBits-1:0] echo_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50 && cfg_m.echo_min_us <= cfg_m.echo_max_us)
      return EchoBits'($urandom_range(cfg_m.echo_max_us, cfg_m.echo_min_us));
    if (r < 65) return '0;
    return EchoBits'($urandom_range(7000));
  endfunction

  // timestamps mostly creep forward, sometimes leap or land anywhere
  function automatic smrc_in_t random_pass();
    smrc_in_t p;
    int unsigned r;
    p = '0;
    r = $urandom_range(99);
    if (r < 2) gen_ms = $urandom;
    else if (r < 8) gen_ms = gen_ms + $urandom_range(200000);
    else gen_ms = gen_ms + $urandom_range(40);
    p.now_ms = gen_ms;
    {p.edge_left_first, p.edge_left_second} = sensor_pair();
    {p.edge_right_first, p.edge_right_second} = sensor_pair();
    p.echo_valid = ($urandom_range(99) < 40);
    p.echo_side = 1'($urandom_range(1));
    p.echo_time_us = echo_sample();
    r = $urandom_range(99);
    if (r < 3) begin
      p.ir_valid = 1'b1;
      p.ir_code = $urandom;
    end else if (r < 6) begin
      p.ir_code = $urandom;
    end
    return p;
  endfunction

  function automatic smrc_in_t code_pass(logic [31:0] code);
    smrc_in_t p;
    p = random_pass();
    p.ir_valid = 1'b1;
    p.ir_code = code;
    return p;
  endfunction

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[CfgDataBits-1:0];
    case (idx)
      CFG_EDGE_THRESHOLD:   cfg_m.edge_threshold = val[AdcBits-1:0];
      CFG_EDGE_ABOVE:       cfg_m.edge_above_polarity = val[0];
      CFG_ECHO_MIN_US:      cfg_m.echo_min_us = val[EchoBits-1:0];
      CFG_ECHO_MAX_US:      cfg_m.echo_max_us = val[EchoBits-1:0];
      CFG_REVERSE_MS:       cfg_m.reverse_ms = val[MsBits-1:0];
      CFG_TURN_MS:          cfg_m.turn_ms = val[MsBits-1:0];
      CFG_TARGET_MEMORY_MS: cfg_m.target_memory_ms = val[MsBits-1:0];
      default:              cfg_m.reading_valid_ms = val[MsBits-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until nothing is queued, offered or outstanding
  task automatic drain();
    do @(negedge clk_i);
    while (pass_q.size() != 0 || req_if.valid || predicted_cmd_q.size() != 0);
  endtask

  // one match under a fixed setting, optionally with a long sink hold-off
  task automatic run_phase(int unsigned thr, pol, mn, mx, rev, trn, mem, vld,
                           int n, bit squeeze);
    int unsigned r;
    write_reg(CFG_EDGE_THRESHOLD, thr);
    write_reg(CFG_EDGE_ABOVE, pol);
    write_reg(CFG_ECHO_MIN_US, mn);
    write_reg(CFG_ECHO_MAX_US, mx);
    write_reg(CFG_REVERSE_MS, rev);
    write_reg(CFG_TURN_MS, trn);
    write_reg(CFG_TARGET_MEMORY_MS, mem);
    write_reg(CFG_READING_VALID_MS, vld);
    pass_q.push_back(code_pass(CodeReady));
    pass_q.push_back(code_pass(CodeStart));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(199);
      if (r == 0) begin
        pass_q.push_back(code_pass(CodeReady));
        pass_q.push_back(code_pass(CodeStart));
      end else if (r == 1) begin
        pass_q.push_back(code_pass(CodeStart));
      end else begin
        pass_q.push_back(random_pass());
      end
    end
    if (squeeze) begin
      while (pass_q.size() > 60) @(negedge clk_i);
      @(posedge clk_i);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      rsp_hold <= 1'b0;
    end
    drain();
  endtask

  // flow pattern is redrawn at random whenever its countdown runs out
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow <= FLOW_FREE;
      flow_left <= 200;
    end else if (flow_left == 0) begin
      flow <= flow_e'($urandom_range(3));
      flow_left <= $urandom_range(400, 100);
    end else begin
      flow_left <= flow_left - 1;
    end
  end

  // request driver: predict on acceptance, then offer the next pass
  always @(posedge clk_i or negedge rst_ni) begin : req_drive
    smrc_out_t exp_r;
    logic gap;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        run_control_pass(req_if.data, exp_r);
        predicted_cmd_q.push_back(exp_r);
      end
      if (!req_if.valid || req_if.ready) begin
        gap = (flow == FLOW_SRC_GAPS && $urandom_range(99) < 45) ||
              (flow == FLOW_BOTH && $urandom_range(99) < 6);
        if (pass_q.size() != 0 && !gap) begin
          req_if.valid <= 1'b1;
          req_if.data <= pass_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : rsp_check
    smrc_out_t want, got;
    logic stall;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        if (predicted_cmd_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result beat %0d arrived with nothing outstanding", beat_cnt);
        end else begin
          want = predicted_cmd_q.pop_front();
          if (got.left_motor_dir !== want.left_motor_dir ||
              got.right_motor_dir !== want.right_motor_dir ||
              got.left_motor_pwm !== want.left_motor_pwm ||
              got.right_motor_pwm !== want.right_motor_pwm ||
              got.match_phase !== want.match_phase ||
              got.ping_request !== want.ping_request ||
              got.ping_target_side !== want.ping_target_side) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch on result beat %0d", beat_cnt);
              $display("  expected ldir %0d rdir %0d lpwm %0d rpwm %0d phase %0d ping %0d side %0d",
                       want.left_motor_dir, want.right_motor_dir, want.left_motor_pwm,
                       want.right_motor_pwm, want.match_phase, want.ping_request,
                       want.ping_target_side);
              $display("  actual   ldir %0d rdir %0d lpwm %0d rpwm %0d phase %0d ping %0d side %0d",
                       got.left_motor_dir, got.right_motor_dir, got.left_motor_pwm,
                       got.right_motor_pwm, got.match_phase, got.ping_request,
                       got.ping_target_side);
            end
          end
        end
        beat_cnt++;
      end
      stall = (flow == FLOW_SNK_STALLS && $urandom_range(99) < 45) ||
              (flow == FLOW_BOTH && $urandom_range(99) < 6);
      rsp_if.ready <= !rsp_hold && !stall;
    end
  end

  // watchdog
  initial begin : watchdog
    for (int c = 0; c < CycleLimit; c++) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned lo;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_EDGE_THRESHOLD;
    cfg_wdata_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // waiting: quiet pass, start out of turn, unknown code with everything high
    pass_q.push_back(mk_pass(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(1, 1, CodeStart, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(2, 1, 32'hFFFF_FFFF, 1023, 1023, 1023, 1023, 1, 1, 7000));
    // ready, then start right before the timestamp wraps: first ping at once
    pass_q.push_back(mk_pass(32'hFFFF_FFC0, 1, CodeReady, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(32'hFFFF_FFE0, 1, CodeStart, 0, 0, 0, 0, 0, 0, 0));
    // left target, then right target across the wrap
    pass_q.push_back(mk_pass(32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 1, 0, 1000));
    pass_q.push_back(mk_pass(5, 0, 0, 0, 0, 0, 0, 1, 1, 300));
    // zero echo time means no echo
    pass_q.push_back(mk_pass(16, 0, 0, 0, 0, 0, 0, 1, 1, 0));
    // one sample per side over the line is not confirmed; window low end
    pass_q.push_back(mk_pass(48, 0, 0, 1023, 0, 0, 1023, 1, 0, 234));
    // start while fighting is ignored; window high end
    pass_q.push_back(mk_pass(64, 1, CodeStart, 0, 0, 0, 0, 1, 1, 4664));
    pass_q.push_back(mk_pass(80, 0, 0, 0, 0, 0, 0, 1, 0, 233));
    pass_q.push_back(mk_pass(96, 0, 0, 0, 0, 0, 0, 1, 1, 4665));
    // stale echoes and expiring memory
    pass_q.push_back(mk_pass(304, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // left line: reverse, drop echo, turn right, turn end
    pass_q.push_back(mk_pass(320, 0, 0, 1023, 1023, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(321, 0, 0, 0, 0, 0, 0, 1, 0, 500));
    pass_q.push_back(mk_pass(570, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(869, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(870, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // right line: turn left
    pass_q.push_back(mk_pass(880, 0, 0, 0, 0, 1023, 1023, 0, 0, 0));
    pass_q.push_back(mk_pass(1130, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(1430, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // both lines, then ready halts mid-escape and start restarts
    pass_q.push_back(mk_pass(1431, 0, 0, 1023, 1023, 1023, 1023, 0, 0, 0));
    pass_q.push_back(mk_pass(1432, 1, CodeReady, 0, 0, 0, 0, 0, 0, 0));
    pass_q.push_back(mk_pass(1433, 1, CodeStart, 0, 0, 0, 0, 0, 0, 0));
    drain();
    gen_ms = 32'd1433;

    // matches under several settings, extremes included
    run_phase(450, 1, 234, 4664, 250, 300, 120, 150, 110, 1'b1);
    run_phase(0, 0, 0, 7000, 0, 0, 65535, 65535, 110, 1'b0);
    run_phase(1023, 1, 0, 0, 100, 100, 0, 0, 100, 1'b0);
    run_phase(512, 0, 7000, 7000, 65535, 0, 300, 300, 110, 1'b0);
    run_phase(1, 0, 100, 6000, 0, 65535, 60, 60, 110, 1'b1);
    run_phase(0, 1, 5000, 100, 30, 30, 200, 40, 100, 1'b0);
    for (int k = 0; k < 2; k++) begin
      lo = $urandom_range(3000);
      run_phase($urandom_range(1023), $urandom_range(1), lo, $urandom_range(7000, lo),
                $urandom_range(400), $urandom_range(400), $urandom_range(300),
                $urandom_range(300), 110, 1'b0);
    end

    // stop is for good: nothing after it revives the robot
    pass_q.push_back(code_pass(CodeReady));
    pass_q.push_back(code_pass(CodeStart));
    for (int i = 0; i < 4; i++) pass_q.push_back(random_pass());
    pass_q.push_back(code_pass(CodeStop));
    pass_q.push_back(code_pass(CodeReady));
    pass_q.push_back(code_pass(CodeStart));
    pass_q.push_back(code_pass($urandom));
    for (int i = 0; i < 5; i++) pass_q.push_back(random_pass());
    pass_q.push_back(code_pass(CodeStop));
    drain();

    repeat (4) @(posedge clk_i);
    err_cnt += predicted_cmd_q.size();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/smrc_pkg.sv
hdl/smrc_if.sv
hdl/sumo_robot_match_controller_core.sv
verif/tb_sumo_robot_match_controller_core.sv
